// File: rtl/core/ddseq_pkg.sv
// ----------------------------------------------------------------------------
// ddseq_pkg
// Shared types and constants for the dtmf dial digit sequencer.
// ----------------------------------------------------------------------------
package ddseq_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int IDX_W      = $clog2(MAX_DIGITS + 2);

    typedef logic [IDX_W-1:0] idx_t;

    localparam logic [3:0]  ZERO_CODE  = 4'd10;
    localparam idx_t        LEAD_COUNT = idx_t'(MAX_DIGITS + 1);
    localparam idx_t        FULL_COUNT = idx_t'(MAX_DIGITS);
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int          RECIP_SHR  = 35;

    typedef struct packed {
        logic [31:0] dial_number;
        logic [3:0]  digit_count;
    } in_word_t;

    typedef struct packed {
        logic [3:0] digit_code;
        logic       last_digit;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic divide;
        logic lead;
        logic emit;
    } ddseq_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic emit_last;
        logic lead_pending;
    } ddseq_status_t;

endpackage

// File: rtl/core/dtmf_dial_digit_sequencer.sv
// ----------------------------------------------------------------------------
// dtmf_dial_digit_sequencer
// Turns a binary phone number into dtmf digit codes, most significant first.
//
//   channel   direction  handshake              word
//   in        input      in_valid / in_ready    in_word_t  (number, count)
//   out       output     out_valid / out_ready  out_word_t (code, last flag)
//
// one number is accepted, its digits are then extracted in the divide-by-ten
// stage, then the codes are sent: n codes for a count n of 1 to 10,
// eleven for a count of 11 (ten digits stored, leading zero code sent first)
// the single reciprocal multiply stage sets the extraction time
// reset clears the sequencer and output valid; no clearing pass is needed
// a stalled output holds the word and pauses emission; in_ready only in idle
// ----------------------------------------------------------------------------
module dtmf_dial_digit_sequencer
    import ddseq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    ddseq_cmd_t    cmd;
    ddseq_status_t status;

    ddseq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ddseq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .cmd      (cmd),
        .status   (status),
        .out_word (out_word)
    );

endmodule

// File: rtl/core/ddseq_datapath.sv
// ----------------------------------------------------------------------------
// ddseq_datapath
// Divide-by-ten digit extraction, digit store and output word register.
// ----------------------------------------------------------------------------
module ddseq_datapath
    import ddseq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  in_word_t      in_word,
    input  ddseq_cmd_t    cmd,
    output ddseq_status_t status,
    output out_word_t     out_word
);

    logic [3:0]  digit_store [MAX_DIGITS];

    logic [31:0] value_reg;
    idx_t        num_reg;
    logic        lead_reg;
    idx_t        fill_reg;
    idx_t        emit_pos_reg;
    out_word_t   out_word_reg;

    idx_t        sat_count;
    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] quot_x10;
    logic [31:0] rem;
    logic [3:0]  digit_code;
    idx_t        fill_idx;

    always_comb
    begin
        if (in_word.digit_count == '0)
            sat_count = idx_t'(1);
        else if (idx_t'(in_word.digit_count) > LEAD_COUNT)
            sat_count = LEAD_COUNT;
        else
            sat_count = idx_t'(in_word.digit_count);
    end

    // value / 10 by reciprocal multiply, remainder by back-multiply
    assign prod       = {32'd0, value_reg} * {32'd0, RECIP_TEN};
    assign quot       = 32'(prod[63:RECIP_SHR]);
    assign quot_x10   = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
    assign rem        = value_reg - quot_x10;
    assign digit_code = (rem[3:0] == 4'd0) ? ZERO_CODE : rem[3:0];
    assign fill_idx   = num_reg - idx_t'(1) - fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg      <= idx_t'(1);
            lead_reg     <= 1'b0;
            fill_reg     <= '0;
            emit_pos_reg <= '0;
        end
        else if (cmd.load)
        begin
            lead_reg     <= (sat_count == LEAD_COUNT);
            num_reg      <= (sat_count == LEAD_COUNT) ? FULL_COUNT : sat_count;
            fill_reg     <= '0;
            emit_pos_reg <= '0;
        end
        else
        begin
            if (cmd.divide)
                fill_reg <= fill_reg + idx_t'(1);
            if (cmd.lead)
                lead_reg <= 1'b0;
            if (cmd.emit)
                emit_pos_reg <= emit_pos_reg + idx_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            value_reg <= in_word.dial_number;
        else if (cmd.divide)
            value_reg <= quot;
        if (cmd.divide)
            digit_store[fill_idx[IDX_W-1:0]] <= digit_code;
        if (cmd.lead)
        begin
            out_word_reg.digit_code <= ZERO_CODE;
            out_word_reg.last_digit <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_word_reg.digit_code <= digit_store[emit_pos_reg];
            out_word_reg.last_digit <= (emit_pos_reg == num_reg - idx_t'(1));
        end
    end

    assign status.fill_last    = (fill_reg == num_reg - idx_t'(1));
    assign status.emit_last    = (emit_pos_reg == num_reg - idx_t'(1));
    assign status.lead_pending = lead_reg;
    assign out_word            = out_word_reg;

endmodule

// File: rtl/core/ddseq_ctrl.sv
// ----------------------------------------------------------------------------
// ddseq_ctrl
// Sequencer for accept, digit extraction and word emission.
// ----------------------------------------------------------------------------
module ddseq_ctrl
    import ddseq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  ddseq_status_t status,
    output ddseq_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_LEAD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.divide = 1'b1;
                if (status.fill_last)
                    state_next = status.lead_pending ? ST_LEAD : ST_EMIT;
            end
            ST_LEAD:
            begin
                if (slot_free)
                begin
                    cmd.lead       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.emit_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: tb/ddseq_checker.sv
// ----------------------------------------------------------------------------
// ddseq_checker
// Watches both channels of the dial digit sequencer. Each accepted number is
// expanded into its expected run of digit codes, and each accepted output
// word is compared field by field against the oldest code still due.
// ----------------------------------------------------------------------------
module ddseq_checker
    import ddseq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_word,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_word,
    output int        mismatches,
    output int        codes_due
);

    out_word_t code_queue[$];

    function automatic void predict_codes(in_word_t w);
        int          cnt;
        bit          lead;
        logic [63:0] rest;
        logic [3:0]  digits[MAX_DIGITS];
        logic [3:0]  d;
        out_word_t   o;
        cnt = int'(w.digit_count);
        if (cnt < 1)
            cnt = 1;
        if (cnt > MAX_DIGITS + 1)
            cnt = MAX_DIGITS + 1;
        lead = (cnt == MAX_DIGITS + 1);
        if (lead)
            cnt = MAX_DIGITS;
        rest = 64'(w.dial_number);
        // least significant digit lands in the last slot
        for (int k = cnt - 1; k >= 0; k--)
        begin
            d         = 4'(rest % 64'd10);
            rest      = rest / 64'd10;
            digits[k] = (d == 4'd0) ? ZERO_CODE : d;
        end
        if (lead)
        begin
            o.digit_code = ZERO_CODE;
            o.last_digit = 1'b0;
            code_queue.push_back(o);
        end
        for (int k = 0; k < cnt; k++)
        begin
            o.digit_code = digits[k];
            o.last_digit = (k == cnt - 1);
            code_queue.push_back(o);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t due;
        if (!rst_n)
        begin
            code_queue.delete();
            codes_due  = 0;
            mismatches = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_codes(in_word);
            if (out_valid && out_ready)
            begin
                if (code_queue.size() == 0)
                    report_mismatch($sformatf("unexpected word code=%0d last=%0b",
                                              out_word.digit_code, out_word.last_digit));
                else
                begin
                    due = code_queue.pop_front();
                    if (out_word.digit_code !== due.digit_code)
                        report_mismatch($sformatf("digit_code %0d, wanted %0d",
                                                  out_word.digit_code, due.digit_code));
                    if (out_word.last_digit !== due.last_digit)
                        report_mismatch($sformatf("last_digit %0b, wanted %0b",
                                                  out_word.last_digit, due.last_digit));
                end
            end
            codes_due = code_queue.size();
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives phone numbers with digit counts into the dial digit sequencer in
// random bursts while the output side stalls on shifting patterns; the
// checker alongside does the prediction, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb
    import ddseq_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 97;
    localparam int DRAIN_CYCLES = 40;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;
    int        mismatches;
    int        codes_due;
    int        cycle_count = 0;
    int        burst_left;
    int        stall_mode = 0;
    int        stall_timer = 0;

    dtmf_dial_digit_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    ddseq_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .mismatches (mismatches),
        .codes_due  (codes_due)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls: the pattern changes every so often
    always @(negedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 120);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= cycle_count[2];
        endcase
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic dial(input logic [31:0] number, input logic [3:0] count);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid             <= 1'b1;
        in_word.dial_number  <= number;
        in_word.digit_count  <= count;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_number();
        logic [31:0] p;
        logic [31:0] n;
        int          sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0: pick_number = $urandom_range(0, 999);
            1:
            begin
                p = 32'd1;
                repeat ($urandom_range(1, 9)) p = p * 32'd10;
                pick_number = p + $urandom_range(0, 2) - 32'd1;
            end
            2:
            begin
                // decimal digits drawn mostly as zeros
                n = 32'd0;
                repeat (9) n = n * 32'd10 + (($urandom_range(0, 2) == 0) ?
                                             $urandom_range(1, 9) : 0);
                pick_number = n;
            end
            default: pick_number = $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_count();
        int x;
        if ($urandom_range(0, 19) != 0)
            pick_count = 4'($urandom_range(1, MAX_DIGITS + 1));
        else
        begin
            x = $urandom_range(0, 4);
            pick_count = (x == 0) ? 4'd0 : 4'(MAX_DIGITS + 1 + x);
        end
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        burst_left  = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed words: extremes, every count, saturating counts
        dial(32'd0, 4'd1);
        dial(32'd0, 4'(MAX_DIGITS));
        dial(32'd0, 4'(MAX_DIGITS + 1));
        dial(32'hFFFF_FFFF, 4'd1);
        dial(32'hFFFF_FFFF, 4'(MAX_DIGITS));
        dial(32'hFFFF_FFFF, 4'(MAX_DIGITS + 1));
        dial(32'd1234567890, 4'(MAX_DIGITS));
        dial(32'd1000000000, 4'(MAX_DIGITS));
        dial(32'd987654321, 4'(MAX_DIGITS + 1));
        dial(32'd7, 4'd0);
        dial(32'd4567, 4'd12);
        dial(32'd2_147_483_648, 4'd15);
        for (int c = 1; c <= MAX_DIGITS + 1; c++)
            dial($urandom, 4'(c));

        for (int i = 0; i < RANDOM_WORDS; i++)
            dial(pick_number(), pick_count());

        in_valid <= 1'b0;
        while (codes_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
